// File: rtl/cps_pkg.sv
// Shared types and constants for the cushion pixel shader pipeline.
package cps_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam logic [16:0] ONE      = 17'(1) << FRAC_BITS;
    localparam logic [17:0] PI_FX    = 18'((64'd3141593 << FRAC_BITS) / 64'd1000000);
    localparam logic [17:0] HALF_PI  = PI_FX >> 1;
    localparam logic [16:0] WAVE_OFS = 17'((3 * (1 << FRAC_BITS)) / 10);

    // Light direction scaled by 100000.
    localparam logic [16:0] L_X     = 17'd9759;
    localparam logic [16:0] L_Y     = 17'd19518;
    localparam logic [16:0] L_Z     = 17'd97590;
    localparam logic [16:0] L_SCALE = 17'd100000;

    // Reciprocals for the constant divisions, truncated.
    localparam logic [18:0] M100 = 19'((1 << 25) / 100);
    localparam logic [15:0] M72  = 16'((1 << 18) / 72);
    localparam logic [15:0] M42  = 16'((1 << 18) / 42);
    localparam logic [15:0] M20  = 16'((1 << 18) / 20);
    localparam logic [15:0] M6   = 16'((1 << 18) / 6);

    // Shading modes.
    localparam logic [2:0] OP_FLAT     = 3'd0;
    localparam logic [2:0] OP_SINE     = 3'd1;
    localparam logic [2:0] OP_PARABOLA = 3'd2;
    localparam logic [2:0] OP_CONE     = 3'd3;
    localparam logic [2:0] OP_WAVE     = 3'd4;
    localparam logic [2:0] OP_CUSHION  = 3'd5;

    // Register index, taken from paddr[2].
    localparam logic REG_AMBIENT = 1'b0;
    localparam logic REG_DIFFUSE = 1'b1;

    localparam logic [7:0] AMBIENT_RESET = 8'd40;
    localparam logic [7:0] DIFFUSE_RESET = 8'd215;

    // Stage schedule.
    localparam int ST_DIV0      = 1;   // 16 steps of the position divider
    localparam int DIV_STEPS    = 16;
    localparam int ST_CPROD     = 1;
    localparam int ST_CSUM      = 2;
    localparam int ST_CABS      = 3;
    localparam int ST_LZA       = 4;
    localparam int ST_LZB       = 5;
    localparam int ST_SHIFT     = 6;
    localparam int ST_SQ        = 7;
    localparam int ST_SUM       = 8;
    localparam int ST_ISQ0      = 9;   // 19 root steps
    localparam int ISQ_STEPS    = 19;
    localparam int ST_DEN       = 28;
    localparam int ST_CDIVF     = 29;
    localparam int ST_CDIV0     = 30;  // 16 quotient steps
    localparam int CDIV_STEPS   = 16;
    localparam int ST_COS       = 46;
    localparam int ST_CUSH      = 47;
    localparam int ST_SIN0      = 16;  // sine step j sits at ST_SIN0 + j
    localparam int ST_BUMP      = 17;
    localparam int ST_SHAPE     = 35;
    localparam int ST_SEL       = 48;
    localparam int ST_RGB       = 49;
    localparam int N_STAGE      = 50;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0][11:0]  pos;
        logic [1:0][12:0]  size;
        logic [1:0][12:0]  odd;
        logic [1:0][31:0]  slope;
        logic [1:0][31:0]  curve;
        logic [2:0][7:0]   base;
        // shape position divider
        logic [1:0][12:0]  drem;
        logic [1:0][15:0]  t;
        // parabola and cone
        logic [1:0][16:0]  bm;
        logic [1:0][32:0]  bmm;
        logic [1:0][16:0]  cone;
        logic [1:0][16:0]  para;
        // sine series
        logic [1:0][24:0]  sn;
        logic [1:0][43:0]  sp;
        logic [1:0][17:0]  sa;
        logic [1:0][16:0]  sb;
        logic [1:0][33:0]  sbb;
        logic [1:0][17:0]  sb2;
        logic [1:0][17:0]  snn;
        logic [1:0][33:0]  sdp;
        logic [1:0][16:0]  sr;
        logic [1:0][34:0]  sm;
        logic [1:0][16:0]  sv;
        logic [16:0]       shape_i;
        // cushion
        logic [1:0][45:0]  cprod;
        logic [1:0][46:0]  csum;
        logic [1:0]        cneg;
        logic [1:0][46:0]  cabs;
        logic [5:0]        gnz;
        logic [5:0][2:0]   gpos;
        logic [4:0]        cshift;
        logic [2:0][17:0]  cv;
        logic [2:0][35:0]  csq;
        logic [2:0][34:0]  cdp;
        logic              dot_pos;
        logic [35:0]       cdot;
        logic [37:0]       qv;
        logic [20:0]       qrem;
        logic [18:0]       qroot;
        logic [36:0]       den;
        logic [36:0]       drm;
        logic [16:0]       cq;
        logic [24:0]       cmul;
        logic [16:0]       cush_i;
        logic [16:0]       inten;
        logic [2:0][7:0]   rgb;
    } item_t;

endpackage

// File: rtl/cushion_pixel_shader_core.sv
// Top level of the cushion pixel shader: config registers and the shading pipeline.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------------------
//  s_*      | in        | s_tvalid / s_tready     | one pixel word, mode on s_tuser
//  m_*      | out       | m_tvalid / m_tready     | shaded RGB word
//  apb      | in        | psel, penable, pready   | ambient_level, diffuse_level
//
// One word enters per clock unless a stall on m_tready backs the pipeline up; its depth is set by
// the cushion path (isqrt of 19 steps, then a 17-step quotient of dot over norm).
// rst_n clears the valid bits and the light registers only; payload is not reset.
// A stall on m_tready holds the last stage; earlier stages keep advancing into
// empty slots, so bubbles are squeezed out and nothing is dropped or repeated.
module cushion_pixel_shader_core
(
    input  logic         clk,
    input  logic         rst_n,
    // pixel input
    input  logic         s_tvalid,
    output logic         s_tready,
    // pixel_x[11:0], pixel_y[23:12], rect_width[36:24], rect_height[49:37],
    // slope_x[81:50], curve_x[113:82], slope_y[145:114], curve_y[177:146],
    // base_red[185:178], base_green[193:186], base_blue[201:194], zero pad
    input  logic [207:0] s_tdata,
    // op[2:0]
    input  logic [2:0]   s_tuser,
    // shaded output
    output logic         m_tvalid,
    input  logic         m_tready,
    // shade_red[7:0], shade_green[15:8], shade_blue[23:16]
    output logic [23:0]  m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NS = cps_pkg::N_STAGE;

    logic [7:0] amb_reg;
    logic [7:0] dif_reg;

    cps_pkg::item_t  pipe_reg  [NS];
    cps_pkg::item_t  pipe_next [NS];
    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   adv;
    cps_pkg::item_t  in_item;

    // ------------------------------------------------------------------
    // Constant-divisor helper: q from a reciprocal product, one correction.
    // Returns ONE - n/dv.
    // ------------------------------------------------------------------
    function automatic logic [16:0] one_minus_quot(input logic [17:0] n,
                                                   input logic [33:0] p,
                                                   input logic [6:0]  dv);
        logic [15:0] q0;
        logic [17:0] rem;
        logic [16:0] q;
        q0  = p[33:18];
        rem = n - 18'(q0) * 18'(dv);
        q   = 17'(q0) + 17'(rem >= 18'(dv));
        return cps_pkg::ONE - q;
    endfunction

    // ------------------------------------------------------------------
    // Work of stage k on the word leaving stage k-1.
    // ------------------------------------------------------------------
    function automatic cps_pkg::item_t stage_fn(input int k, input cps_pkg::item_t d,
                                                input logic [7:0] amb,
                                                input logic [7:0] dif);
        cps_pkg::item_t     q;
        logic [13:0]        r2;
        logic [16:0]        two;
        logic [25:0]        rem26;
        logic [18:0]        q19;
        logic [47:0]        orw;
        logic [7:0]         byt;
        logic [5:0]         len;
        logic signed [45:0] cu46;
        logic signed [45:0] od46;
        logic signed [46:0] s47;
        logic signed [37:0] tx;
        logic signed [37:0] ty;
        logic signed [37:0] tz;
        logic signed [37:0] dot;
        logic [22:0]        rem2;
        logic [22:0]        trial;
        logic [18:0]        rt;
        logic [37:0]        dr2;
        logic [16:0]        cosv;
        logic [25:0]        isum;
        logic [17:0]        ish;
        logic [24:0]        prod;
        logic [17:0]        ssum;
        logic [18:0]        sfin;
        int                 a;
        int                 g;
        int                 b;
        int                 j;
        q = d;
        j = k - cps_pkg::ST_SIN0;

        // position divider: t = pos * ONE / size, one bit a stage
        if (k >= cps_pkg::ST_DIV0 && k < cps_pkg::ST_DIV0 + cps_pkg::DIV_STEPS) begin
            for (a = 0; a < 2; a++) begin
                r2 = {d.drem[a], 1'b0};
                if (r2 >= 14'(d.size[a])) begin
                    q.drem[a] = 13'(r2 - 14'(d.size[a]));
                    q.t[a]    = {d.t[a][14:0], 1'b1};
                end
                else begin
                    q.drem[a] = 13'(r2);
                    q.t[a]    = {d.t[a][14:0], 1'b0};
                end
            end
        end

        // parabola and cone
        if (k == cps_pkg::ST_BUMP) begin
            for (a = 0; a < 2; a++) begin
                two = {d.t[a], 1'b0};
                q.bm[a] = d.t[a][15] ? two - cps_pkg::ONE : cps_pkg::ONE - two;
            end
        end
        if (k == cps_pkg::ST_BUMP + 1) begin
            for (a = 0; a < 2; a++) begin
                q.bmm[a]  = 33'(d.bm[a]) * 33'(d.bm[a]);
                q.cone[a] = cps_pkg::ONE - d.bm[a];
            end
        end
        if (k == cps_pkg::ST_BUMP + 2) begin
            for (a = 0; a < 2; a++) begin
                q.para[a] = cps_pkg::ONE - d.bmm[a][32:16];
            end
        end

        // sine series
        for (a = 0; a < 2; a++) begin
            if (j == 1) begin
                q.sn[a] = 25'(d.t[a]) * 25'(314);
            end
            if (j == 2) begin
                q.sp[a] = 44'(d.sn[a]) * 44'(cps_pkg::M100);
            end
            if (j == 3) begin
                q19     = d.sp[a][43:25];
                rem26   = 26'(d.sn[a]) - 26'(q19) * 26'(100);
                q.sa[a] = 18'(q19) + 18'(rem26 >= 26'(100));
            end
            if (j == 4) begin
                q.sb[a] = 17'((d.sa[a] > cps_pkg::HALF_PI) ? cps_pkg::PI_FX - d.sa[a]
                                                           : d.sa[a]);
            end
            if (j == 5) begin
                q.sbb[a] = 34'(d.sb[a]) * 34'(d.sb[a]);
            end
            if (j == 6) begin
                q.sb2[a] = d.sbb[a][33:16];
                q.snn[a] = d.sbb[a][33:16];
                q.sdp[a] = 34'(d.sbb[a][33:16]) * 34'(cps_pkg::M72);
            end
            if (j == 9 || j == 12 || j == 15) begin
                q.snn[a] = d.sm[a][33:16];
                unique case (j)
                    9:       q.sdp[a] = 34'(d.sm[a][33:16]) * 34'(cps_pkg::M42);
                    12:      q.sdp[a] = 34'(d.sm[a][33:16]) * 34'(cps_pkg::M20);
                    default: q.sdp[a] = 34'(d.sm[a][33:16]) * 34'(cps_pkg::M6);
                endcase
            end
            if (j == 7) begin
                q.sr[a] = one_minus_quot(d.snn[a], d.sdp[a], 7'd72);
            end
            if (j == 10) begin
                q.sr[a] = one_minus_quot(d.snn[a], d.sdp[a], 7'd42);
            end
            if (j == 13) begin
                q.sr[a] = one_minus_quot(d.snn[a], d.sdp[a], 7'd20);
            end
            if (j == 16) begin
                q.sr[a] = one_minus_quot(d.snn[a], d.sdp[a], 7'd6);
            end
            if (j == 8 || j == 11 || j == 14) begin
                q.sm[a] = 35'(d.sb2[a]) * 35'(d.sr[a]);
            end
            if (j == 17) begin
                q.sm[a] = 35'(d.sb[a]) * 35'(d.sr[a]);
            end
            if (j == 18) begin
                sfin    = d.sm[a][34:16];
                q.sv[a] = (sfin > 19'(cps_pkg::ONE)) ? cps_pkg::ONE : 17'(sfin);
            end
        end

        // shape intensity by mode
        if (k == cps_pkg::ST_SHAPE) begin
            ssum = 18'(d.sv[0]) + 18'(d.sv[1]);
            unique case (d.op)
                cps_pkg::OP_FLAT:     q.shape_i = cps_pkg::ONE;
                cps_pkg::OP_SINE:     q.shape_i = ssum[17:1];
                cps_pkg::OP_PARABOLA: q.shape_i = 17'((18'(d.para[0]) + 18'(d.para[1])) >> 1);
                cps_pkg::OP_CONE:     q.shape_i = 17'((18'(d.cone[0]) + 18'(d.cone[1])) >> 1);
                cps_pkg::OP_WAVE:     q.shape_i = 17'(ssum >> 2) + cps_pkg::WAVE_OFS;
                default:              q.shape_i = '0;
            endcase
        end

        // cushion normal: n = -(curve * (2p+1) + slope)
        if (k == cps_pkg::ST_CPROD) begin
            for (a = 0; a < 2; a++) begin
                cu46       = 46'($signed(d.curve[a]));
                od46       = $signed(46'(d.odd[a]));
                q.cprod[a] = cu46 * od46;
            end
        end
        if (k == cps_pkg::ST_CSUM) begin
            for (a = 0; a < 2; a++) begin
                q.csum[a] = 47'($signed(d.cprod[a])) + 47'($signed(d.slope[a]));
            end
        end
        if (k == cps_pkg::ST_CABS) begin
            for (a = 0; a < 2; a++) begin
                s47       = $signed(d.csum[a]);
                q.cneg[a] = (s47 > 0);
                q.cabs[a] = (s47 < 0) ? 47'(-s47) : 47'(s47);
            end
        end

        // leading one of max(|nx|,|ny|,ONE), in byte groups
        if (k == cps_pkg::ST_LZA) begin
            orw = {1'b0, d.cabs[0] | d.cabs[1] | 47'(cps_pkg::ONE)};
            for (g = 0; g < 6; g++) begin
                byt       = orw[g*8 +: 8];
                q.gnz[g]  = |byt;
                q.gpos[g] = '0;
                for (b = 0; b < 8; b++) begin
                    if (byt[b]) begin
                        q.gpos[g] = 3'(b);
                    end
                end
            end
        end
        if (k == cps_pkg::ST_LZB) begin
            len = '0;
            for (g = 0; g < 6; g++) begin
                if (d.gnz[g]) begin
                    len = 6'(g * 8) + 6'(d.gpos[g]) + 6'd1;
                end
            end
            q.cshift = (len > 6'd18) ? 5'(len - 6'd18) : '0;
        end
        if (k == cps_pkg::ST_SHIFT) begin
            q.cv[0] = 18'(d.cabs[0] >> d.cshift);
            q.cv[1] = 18'(d.cabs[1] >> d.cshift);
            q.cv[2] = 18'(47'(cps_pkg::ONE) >> d.cshift);
        end
        if (k == cps_pkg::ST_SQ) begin
            for (a = 0; a < 3; a++) begin
                q.csq[a] = 36'(d.cv[a]) * 36'(d.cv[a]);
            end
            q.cdp[0] = 35'(d.cv[0]) * 35'(cps_pkg::L_X);
            q.cdp[1] = 35'(d.cv[1]) * 35'(cps_pkg::L_Y);
            q.cdp[2] = 35'(d.cv[2]) * 35'(cps_pkg::L_Z);
        end
        if (k == cps_pkg::ST_SUM) begin
            tx = $signed(38'(d.cdp[0]));
            ty = $signed(38'(d.cdp[1]));
            tz = $signed(38'(d.cdp[2]));
            if (d.cneg[0]) begin
                tx = -tx;
            end
            if (d.cneg[1]) begin
                ty = -ty;
            end
            dot       = tx + ty + tz;
            q.dot_pos = (dot > 0);
            q.cdot    = (dot > 0) ? 36'(dot) : '0;
            q.qv      = 38'(d.csq[0]) + 38'(d.csq[1]) + 38'(d.csq[2]);
            q.qrem    = '0;
            q.qroot   = '0;
        end

        // integer square root, one result bit a stage
        if (k >= cps_pkg::ST_ISQ0 && k < cps_pkg::ST_ISQ0 + cps_pkg::ISQ_STEPS) begin
            rem2  = {d.qrem, d.qv[37:36]};
            trial = {2'b00, d.qroot, 2'b01};
            if (rem2 >= trial) begin
                q.qrem  = 21'(rem2 - trial);
                q.qroot = {d.qroot[17:0], 1'b1};
            end
            else begin
                q.qrem  = 21'(rem2);
                q.qroot = {d.qroot[17:0], 1'b0};
            end
            q.qv = {d.qv[35:0], 2'b00};
        end
        if (k == cps_pkg::ST_DEN) begin
            rt    = (d.qroot == '0) ? 19'd1 : d.qroot;
            q.den = 37'(rt) * 37'(cps_pkg::L_SCALE);
        end

        // cos = dot * ONE / den; the quotient stays below 2 * ONE
        if (k == cps_pkg::ST_CDIVF) begin
            if (37'(d.cdot) >= d.den) begin
                q.drm = 37'(d.cdot) - d.den;
                q.cq  = 17'd1;
            end
            else begin
                q.drm = 37'(d.cdot);
                q.cq  = '0;
            end
        end
        if (k >= cps_pkg::ST_CDIV0 && k < cps_pkg::ST_CDIV0 + cps_pkg::CDIV_STEPS) begin
            dr2 = {d.drm, 1'b0};
            if (dr2 >= 38'(d.den)) begin
                q.drm = 37'(dr2 - 38'(d.den));
                q.cq  = {d.cq[15:0], 1'b1};
            end
            else begin
                q.drm = 37'(dr2);
                q.cq  = {d.cq[15:0], 1'b0};
            end
        end
        if (k == cps_pkg::ST_COS) begin
            cosv   = !d.dot_pos ? '0 : ((d.cq > cps_pkg::ONE) ? cps_pkg::ONE : d.cq);
            q.cmul = 25'(dif) * 25'(cosv);
        end
        if (k == cps_pkg::ST_CUSH) begin
            isum     = {2'b00, amb, 16'h0000} + 26'(d.cmul);
            ish      = isum[25:8];
            q.cush_i = (ish > 18'(cps_pkg::ONE)) ? cps_pkg::ONE : 17'(ish);
        end

        if (k == cps_pkg::ST_SEL) begin
            q.inten = (d.op == cps_pkg::OP_CUSHION) ? d.cush_i : d.shape_i;
        end
        if (k == cps_pkg::ST_RGB) begin
            for (a = 0; a < 3; a++) begin
                prod     = 25'(d.base[a]) * 25'(d.inten);
                q.rgb[a] = prod[24] ? 8'hFF : prod[23:16];
            end
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amb_reg <= cps_pkg::AMBIENT_RESET;
            dif_reg <= cps_pkg::DIFFUSE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == cps_pkg::REG_AMBIENT)
            begin
                amb_reg <= pwdata[7:0];
            end
            else
            begin
                dif_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == cps_pkg::REG_DIFFUSE)
        begin
            prdata = {24'h0, dif_reg};
        end
        else
        begin
            prdata = {24'h0, amb_reg};
        end
    end

    // ------------------------------------------------------------------
    // Capture: unpack the word, force tiny sizes to 1, clamp the position.
    // ------------------------------------------------------------------
    always_comb
    begin
        in_item          = '0;
        in_item.op       = s_tuser;
        in_item.slope[0] = s_tdata[81:50];
        in_item.curve[0] = s_tdata[113:82];
        in_item.slope[1] = s_tdata[145:114];
        in_item.curve[1] = s_tdata[177:146];
        in_item.base[0]  = s_tdata[185:178];
        in_item.base[1]  = s_tdata[193:186];
        in_item.base[2]  = s_tdata[201:194];
        in_item.odd[0]   = {s_tdata[11:0], 1'b1};
        in_item.odd[1]   = {s_tdata[23:12], 1'b1};
        in_item.size[0]  = (s_tdata[36:24] <= 13'd1) ? 13'd1 : s_tdata[36:24];
        in_item.size[1]  = (s_tdata[49:37] <= 13'd1) ? 13'd1 : s_tdata[49:37];
        in_item.pos[0]   = (13'(s_tdata[11:0]) > in_item.size[0] - 13'd1)
                           ? 12'(in_item.size[0] - 13'd1) : s_tdata[11:0];
        in_item.pos[1]   = (13'(s_tdata[23:12]) > in_item.size[1] - 13'd1)
                           ? 12'(in_item.size[1] - 13'd1) : s_tdata[23:12];
        // divider starts with the position as its remainder
        in_item.drem[0]  = 13'(in_item.pos[0]);
        in_item.drem[1]  = 13'(in_item.pos[1]);
    end

    // ------------------------------------------------------------------
    // Pipeline: a stage advances when it is empty or the next one advances.
    // ------------------------------------------------------------------
    assign adv[NS-1]  = !vld_reg[NS-1] || m_tready;
    assign s_tready   = adv[0];
    assign pipe_next[0] = in_item;

    for (genvar gi = 0; gi < NS - 1; gi++)
    begin : g_adv
        assign adv[gi] = !vld_reg[gi] || adv[gi+1];
    end

    for (genvar gi = 1; gi < NS; gi++)
    begin : g_stage
        assign pipe_next[gi] = stage_fn(gi, pipe_reg[gi-1], amb_reg, dif_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Payload carries no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (adv[i])
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = {pipe_reg[NS-1].rgb[2], pipe_reg[NS-1].rgb[1], pipe_reg[NS-1].rgb[0]};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // Input backs up only behind a full pipeline stuck at the output.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // The first quotient step must leave a remainder below the divisor.
    a_cdiv_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[cps_pkg::ST_CDIVF] |->
            (pipe_reg[cps_pkg::ST_CDIVF].drm < pipe_reg[cps_pkg::ST_CDIVF].den))
        else $error("cosine quotient overflow");

    // The chosen intensity never exceeds one.
    a_inten_max: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[cps_pkg::ST_SEL] |-> (pipe_reg[cps_pkg::ST_SEL].inten <= cps_pkg::ONE))
        else $error("intensity above one");

    // A flat pixel passes its base colour unchanged.
    a_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && pipe_reg[NS-1].op == cps_pkg::OP_FLAT) |->
            (pipe_reg[NS-1].rgb == pipe_reg[NS-1].base))
        else $error("flat mode altered the colour");

endmodule

// File: dv/cushion_pixel_shader_core_test.sv
// Self-checking testbench for the cushion pixel shader core.
`timescale 1ns / 1ps

module cushion_pixel_shader_core_test;

    localparam int LATENCY = 60;
    localparam longint PI_Q = (64'd3141593 << 16) / 64'd1000000;
    localparam longint UNIT = 64'd65536;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [207:0] s_tdata;   // pixel_x, pixel_y, rect_width, rect_height, slope_x,
                             // curve_x, slope_y, curve_y, base_red, base_green,
                             // base_blue, zero pad
    logic [2:0]   s_tuser;   // op
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;   // shade_red, shade_green, shade_blue
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] px;
        logic [11:0] py;
        logic [12:0] w;
        logic [12:0] h;
        logic [31:0] sx;
        logic [31:0] cx;
        logic [31:0] sy;
        logic [31:0] cy;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } pixel_t;

    // Shadow copy of the light registers
    logic [7:0]   ambient_q;
    logic [7:0]   diffuse_q;

    logic [23:0]  colour_queue[$];
    int           mismatches;
    bit           sink_stall;      // random stalls on the output side
    bit           source_gaps;     // random gaps on the input side
    bit           hold_output;     // long back-pressure stretch

    cushion_pixel_shader_core i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    //------------------------------------------------------------------
    // Prediction
    //------------------------------------------------------------------
    function automatic longint unsigned pos_fraction(logic [11:0] p, logic [12:0] s);
        longint unsigned n;
        longint unsigned q;
        n = (s <= 1) ? 1 : s;
        q = p;
        if (q > n - 1)
            q = n - 1;
        return (q << 16) / n;
    endfunction

    function automatic longint unsigned sine_q(longint unsigned t);
        longint unsigned a;
        longint unsigned bb;
        longint unsigned b2;
        longint unsigned r;
        a  = (t * 314) / 100;
        bb = (a > (PI_Q >> 1)) ? PI_Q - a : a;
        b2 = (bb * bb) >> 16;
        r  = UNIT - b2 / 72;
        r  = UNIT - ((b2 * r) >> 16) / 42;
        r  = UNIT - ((b2 * r) >> 16) / 20;
        r  = UNIT - ((b2 * r) >> 16) / 6;
        r  = (bb * r) >> 16;
        return (r > UNIT) ? UNIT : r;
    endfunction

    function automatic longint unsigned hump_q(longint unsigned t, bit pointed);
        longint d;
        longint unsigned m;
        d = 2 * longint'(t) - longint'(UNIT);
        m = (d < 0) ? -d : d;
        return pointed ? UNIT - m : UNIT - ((m * m) >> 16);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned cushion_q(pixel_t p);
        longint nx;
        longint ny;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned az;
        longint unsigned m;
        longint dot;
        longint unsigned cq;
        longint unsigned nrm;
        longint unsigned lit;
        int k;
        nx = -(longint'($signed(p.cx)) * longint'(2 * p.px + 1) + longint'($signed(p.sx)));
        ny = -(longint'($signed(p.cy)) * longint'(2 * p.py + 1) + longint'($signed(p.sy)));
        ax = (nx < 0) ? -nx : nx;
        ay = (ny < 0) ? -ny : ny;
        az = UNIT;
        m = (ax > ay) ? ax : ay;
        if (az > m)
            m = az;
        k = 0;
        while ((m >> k) >= (64'd1 << 18))
            k++;
        ax >>= k;
        ay >>= k;
        az >>= k;
        dot = ((nx < 0) ? -longint'(ax) : longint'(ax)) * 9759
            + ((ny < 0) ? -longint'(ay) : longint'(ay)) * 19518
            + longint'(az) * 97590;
        cq = 0;
        if (dot > 0)
        begin
            nrm = root_floor(ax * ax + ay * ay + az * az);
            if (nrm == 0)
                nrm = 1;
            cq = (longint'(dot) << 16) / (nrm * 100000);
            if (cq > UNIT)
                cq = UNIT;
        end
        lit = (ambient_q * UNIT + diffuse_q * cq) >> 8;
        return (lit > UNIT) ? UNIT : lit;
    endfunction

    function automatic logic [23:0] shaded_colour(pixel_t p);
        longint unsigned tx;
        longint unsigned ty;
        longint unsigned lvl;
        longint unsigned v;
        logic [7:0] base[3];
        logic [23:0] res;
        tx = pos_fraction(p.px, p.w);
        ty = pos_fraction(p.py, p.h);
        case (p.op)
            cps_pkg::OP_FLAT:     lvl = UNIT;
            cps_pkg::OP_SINE:     lvl = (sine_q(tx) + sine_q(ty)) >> 1;
            cps_pkg::OP_PARABOLA: lvl = (hump_q(tx, 0) + hump_q(ty, 0)) >> 1;
            cps_pkg::OP_CONE:     lvl = (hump_q(tx, 1) + hump_q(ty, 1)) >> 1;
            cps_pkg::OP_WAVE:     lvl = ((sine_q(tx) + sine_q(ty)) >> 2) + (3 * UNIT) / 10;
            cps_pkg::OP_CUSHION:  lvl = cushion_q(p);
            default:              lvl = 0;
        endcase
        base[0] = p.r;
        base[1] = p.g;
        base[2] = p.b;
        for (int c = 0; c < 3; c++)
        begin
            v = (base[c] * lvl) >> 16;
            res[8*c +: 8] = (v > 255) ? 8'd255 : v[7:0];
        end
        return res;
    endfunction

    //------------------------------------------------------------------
    // Shared drivers
    //------------------------------------------------------------------
    // Offer one pixel word, hold it until taken, then predict its colour.
    task automatic send_pixel(pixel_t p);
        int gap;
        if (source_gaps && ($urandom_range(0, 3) == 0))
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= p.op;
        s_tdata  <= {6'd0, p.b, p.g, p.r, p.cy, p.sy, p.cx, p.sx, p.h, p.w, p.py, p.px};
        do
            @(posedge clk);
        while (!s_tready);
        colour_queue.push_back(shaded_colour(p));
    endtask

    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        while (colour_queue.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    // Registers are only touched with the pipeline empty.
    task automatic write_reg(logic idx, logic [7:0] val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == cps_pkg::REG_AMBIENT)
            ambient_q = val;
        else
            diffuse_q = val;
        // read back the register just written
        @(posedge clk);
        if (prdata !== {24'h0, val} || pready !== 1'b1)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register read: expected %0d, got %0d", val, prdata);
        end
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = pixel_t'(205'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom}));
        p.op = 3'($urandom_range(0, 7));
        // mostly modest rectangles with the pixel inside, now and then anything
        if ($urandom_range(0, 3) != 0)
        begin
            p.w = 13'($urandom_range(0, 300));
            p.h = 13'($urandom_range(0, 300));
            p.px = (p.w > 1) ? 12'($urandom_range(0, p.w - 1)) : 12'd0;
            p.py = (p.h > 1) ? 12'($urandom_range(0, p.h - 1)) : 12'd0;
        end
        else
        begin
            p.w = 13'($urandom_range(0, 4096));
            p.h = 13'($urandom_range(0, 4096));
        end
        // cushion coefficients: small ones give lit surfaces, large ones test scaling
        if ($urandom_range(0, 2) != 0)
        begin
            p.sx = $signed($urandom_range(0, 200000)) - 100000;
            p.sy = $signed($urandom_range(0, 200000)) - 100000;
            p.cx = $signed($urandom_range(0, 2000)) - 1000;
            p.cy = $signed($urandom_range(0, 2000)) - 1000;
        end
        return p;
    endfunction

    //------------------------------------------------------------------
    // Result checker and output stalls
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (colour_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", m_tdata);
            end
            else
            begin
                logic [23:0] want;
                want = colour_queue.pop_front();
                if (want !== m_tdata)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("colour mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                                 want[7:0], want[15:8], want[23:16],
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
                end
            end
        end
    end

    initial
    begin
        int burst;
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_output = 0;
                m_tready <= 1'b1;
            end
            else if (sink_stall && ($urandom_range(0, 3) == 0))
            begin
                burst = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (burst) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_directed_modes();
        pixel_t p;
        for (int op = 0; op < 8; op++)
        begin
            p = '0;
            p.op = 3'(op);
            p.px = 3; p.py = 5; p.w = 10; p.h = 7;
            p.r = 8'hff; p.g = 8'h80; p.b = 8'h01;
            p.cx = -32'sd500; p.sx = 32'sd2000; p.cy = 32'sd300; p.sy = -32'sd4000;
            send_pixel(p);
        end
        // degenerate sizes and positions outside the rectangle
        p = '0; p.op = cps_pkg::OP_SINE; p.w = 0; p.h = 1; p.px = 12'hfff; p.py = 12'hfff;
        p.r = 8'hff; p.g = 8'hff; p.b = 8'hff;
        send_pixel(p);
        p.op = cps_pkg::OP_CONE; p.w = 13'd4096; p.h = 13'd4096; p.px = 12'hfff; p.py = 0;
        send_pixel(p);
        p.op = cps_pkg::OP_PARABOLA; p.w = 13'd2; p.h = 13'd4095; p.px = 12'hfff;
        p.py = 12'd2047;
        send_pixel(p);
        p.op = cps_pkg::OP_WAVE; p.w = 13'd8191; p.h = 13'd3; send_pixel(p);
        // cushion: extreme coefficients, flat surface, lit and unlit normals
        p = '0; p.op = cps_pkg::OP_CUSHION; p.r = 8'hff; p.g = 8'h7f; p.b = 8'hc3;
        send_pixel(p);
        p.px = 12'hfff; p.py = 12'hfff;
        p.sx = 32'h8000_0000; p.cx = 32'h7fff_ffff; p.sy = 32'h7fff_ffff; p.cy = 32'h8000_0000;
        send_pixel(p);
        p.sx = 32'h7fff_ffff; p.cx = 32'h7fff_ffff; p.sy = 32'h7fff_ffff; p.cy = 32'h7fff_ffff;
        send_pixel(p);
        p.sx = 32'h8000_0000; p.cx = 32'h8000_0000; p.sy = 32'h8000_0000; p.cy = 32'h8000_0000;
        send_pixel(p);
        p.px = 0; p.py = 0; p.cx = 0; p.cy = 0; p.sx = 0; p.sy = -32'sd9000000;
        send_pixel(p);
        p.sy = 32'sd9000000; send_pixel(p);
    endtask

    task automatic test_random_pixels(int count);
        for (int n = 0; n < count; n++)
            send_pixel(random_pixel());
    endtask

    task automatic test_light_levels();
        logic [7:0] amb[4];
        logic [7:0] dif[4];
        pixel_t p;
        amb = '{8'd0, 8'd255, 8'd0, 8'd255};
        dif = '{8'd0, 8'd255, 8'd255, 8'd0};
        for (int s = 0; s < 4; s++)
        begin
            write_reg(cps_pkg::REG_AMBIENT, amb[s]);
            write_reg(cps_pkg::REG_DIFFUSE, dif[s]);
            for (int n = 0; n < 60; n++)
            begin
                p = random_pixel();
                if (n % 2 == 0)
                    p.op = cps_pkg::OP_CUSHION;
                send_pixel(p);
            end
        end
        write_reg(cps_pkg::REG_AMBIENT, 8'($urandom_range(0, 255)));
        write_reg(cps_pkg::REG_DIFFUSE, 8'($urandom_range(0, 255)));
        test_random_pixels(80);
    endtask

    task automatic test_backpressure();
        drain();
        hold_output = 1;
        test_random_pixels(120);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        mismatches = 0;
        ambient_q = 8'd40;
        diffuse_q = 8'd215;
        sink_stall = 0;
        source_gaps = 0;
        hold_output = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_modes();
        sink_stall = 1;
        source_gaps = 1;
        test_random_pixels(500);
        test_light_levels();
        test_backpressure();
        test_random_pixels(200);
        // last stretch at full rate on both sides
        sink_stall = 0;
        source_gaps = 0;
        test_random_pixels(200);
        drain();

        if (mismatches == 0 && colour_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
